### rtl/acs_pkg.sv
// shared constants, status codes and seed rule table for the chemistry step
package acs_pkg;

    localparam int CHEMICAL_KINDS_DEF  = 100;
    localparam int RULE_DEPTH_DEF      = 1024;
    localparam int MOLECULE_POOL_DEF   = 100000;

    localparam int DRAW_W   = 32;
    localparam int SUPPLY_W = 10;
    localparam int LIMIT_W  = 11;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 3;
    localparam int SEED_W   = 8;
    localparam int SEED_COUNT = 4;

    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 10'd10;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1000;

    localparam logic CFG_SUPPLY = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OLD   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ  = 3'd4;

    // seed rules packed as reactants then products, one byte per chemical
    function automatic logic [6*SEED_W-1:0] seed_rule(input logic [1:0] idx);
        logic [6*SEED_W-1:0] v;
        case (idx)
            2'd0:    v = {8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd1};
            2'd1:    v = {8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd2};
            2'd2:    v = {8'd0, 8'd1, 8'd2, 8'd0, 8'd0, 8'd3};
            default: v = {8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd2};
        endcase
        return v;
    endfunction

endpackage

### rtl/artificial_chemistry_step.sv
// mean-field artificial chemistry timestep engine with count and rule memories
// a read word looks up one count; a step word supplies, samples, sorts, checks counts, searches the
//   rules and, when a new rule is made, walks the (p1,p2) pairs twice (K = CHEMICAL_KINDS)
// throughput: one word at a time; the rule search and the product pair walk set the rate
// reset (synchronous, active low): counts read as the whole pool in chemical zero and empty
//   elsewhere through per-entry valid bits, four seed rules come from a constant table, no clearing pass
module artificial_chemistry_step #(
    parameter int CHEMICAL_KINDS  = acs_pkg::CHEMICAL_KINDS_DEF,
    parameter int RULE_DEPTH      = acs_pkg::RULE_DEPTH_DEF,
    parameter int MOLECULE_POOL   = acs_pkg::MOLECULE_POOL_DEF,
    localparam int KW = $clog2(CHEMICAL_KINDS + 1),
    localparam int CW = $clog2(MOLECULE_POOL + 1),
    localparam int SW = $clog2(RULE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [acs_pkg::CFG_W-1:0]     i_cfg_data,
    // input word
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [acs_pkg::DRAW_W-1:0]    i_first_draw,
    input  logic [acs_pkg::DRAW_W-1:0]    i_second_draw,
    input  logic [acs_pkg::DRAW_W-1:0]    i_third_draw,
    input  logic [acs_pkg::DRAW_W-1:0]    i_product_draw,
    input  logic [KW-1:0]                 i_chemical_index,
    // result word
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [acs_pkg::STATUS_W-1:0]  o_status,
    output logic [KW-1:0]                 o_reactant_low,
    output logic [KW-1:0]                 o_reactant_mid,
    output logic [KW-1:0]                 o_reactant_high,
    output logic [KW-1:0]                 o_product_low,
    output logic [KW-1:0]                 o_product_mid,
    output logic [KW-1:0]                 o_product_high,
    output logic [SW-1:0]                 o_rule_slot,
    output logic [CW-1:0]                 o_count_value
);
    import acs_pkg::*;

    localparam int NK = CHEMICAL_KINDS + 1;     // entries in the count memory
    localparam int UW = $clog2(RULE_DEPTH + 1); // rules in use, up to the depth
    localparam int MW = KW + 2;                 // reactant mass, up to 3*K
    localparam int PW = KW + 1;                 // pair walk indexes, up to K+1
    localparam int NW = 3 * KW;                 // number of product triples
    localparam int BW = (CW > NW) ? CW : NW;    // shared multiplier operand
    localparam int TW = (CW > SUPPLY_W) ? CW : SUPPLY_W;
    localparam int LW = (UW > LIMIT_W) ? UW : LIMIT_W;
    localparam int EW = 6 * KW;                 // rule entry: reactants then products

    typedef enum logic [4:0] {
        S_IDLE, S_RD_ISS, S_RD_USE, S_SUP_ISS, S_SUP_USE, S_MUL,
        S_WK_ISS, S_WK_USE, S_SORT, S_ND_ISS, S_ND_USE, S_SR_ISS, S_SR_USE,
        S_MISS, S_ENUM, S_KMUL, S_WRULE, S_AP_ISS, S_AP_USE, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [SUPPLY_W-1:0] r_supply;
    logic [LIMIT_W-1:0]  r_limit;

    // latched input word
    logic [DRAW_W-1:0] r_draw [4];
    logic [KW-1:0]     r_idx;

    // working registers
    logic [2:0]        r_op;
    logic [TW-1:0]     r_t;
    logic [CW-1:0]     r_tgt [3];
    logic [KW-1:0]     r_wc;
    logic [CW-1:0]     r_acc;
    logic [2:0]        r_got;
    logic [KW-1:0]     r_r [3];
    logic [KW-1:0]     r_s [3];
    logic [KW-1:0]     r_p [3];
    logic [UW-1:0]     r_si;
    logic [UW-1:0]     r_used;
    logic [SW-1:0]     r_slot;
    logic [CW-1:0]     r_cntv;
    logic [STATUS_W-1:0] r_status;
    logic [MW-1:0]     r_m;
    logic [PW-1:0]     r_p1;
    logic [PW-1:0]     r_p2;
    logic [NW-1:0]     r_eacc;
    logic [NW-1:0]     r_n;
    logic [NW-1:0]     r_k;
    logic              r_pass;

    // count memory with per-entry valid bits
    logic [CW-1:0] r_cnt_mem [NK];
    logic          r_cnt_vld [NK];
    logic [CW-1:0] r_cnt_q;
    logic          r_cq_v;
    logic [KW-1:0] r_cq_a;
    logic [KW-1:0] cnt_ra;
    logic          cnt_we;
    logic [CW-1:0] cnt_wd;
    logic [CW-1:0] cnt_val;

    // rule memory, seed slots overlaid from the constant table
    logic [EW-1:0] r_rule_mem [RULE_DEPTH];
    logic [EW-1:0] r_rule_q;
    logic          r_rq_seed;
    logic [1:0]    r_rq_idx;
    logic [EW-1:0] seed_ent;
    logic [EW-1:0] rule_ent;
    logic [6*SEED_W-1:0] seed_raw;

    // shared multiplier
    logic [DRAW_W-1:0]    mul_a;
    logic [BW-1:0]        mul_b;
    logic [DRAW_W+BW-1:0] mul_p;

    // misc combinational
    logic [TW-1:0]   sup_t;
    logic [CW:0]     acc_n;
    logic [KW-1:0]   srt [3];
    logic [KW-1:0]   tmp;
    logic [1:0]      need;
    logic [MW-1:0]   sum12;
    logic [MW-1:0]   hi;
    logic [MW-1:0]   hic;
    logic [MW-1:0]   span_m;
    logic [NW-1:0]   span;
    logic [NW-1:0]   k_off;
    logic [LW-1:0]   lim;
    logic            full;
    logic [KW-1:0]   ap_addr;

    assign o_ready = (r_state == S_IDLE);

    // count memory value, unwritten entries read as reset contents
    assign cnt_val = r_cq_v ? r_cnt_q :
                     ((r_cq_a == '0) ? CW'(MOLECULE_POOL) : '0);

    assign seed_raw = seed_rule(r_rq_idx);
    always_comb begin
        for (int f = 0; f < 6; f++) begin
            seed_ent[KW*f +: KW] = seed_raw[SEED_W*f +: KW];
        end
    end
    assign rule_ent = r_rq_seed ? seed_ent : r_rule_q;

    assign mul_a = (r_state == S_KMUL) ? r_draw[3] : r_draw[r_op[1:0]];
    assign mul_b = (r_state == S_KMUL) ? BW'(r_n) : BW'(MOLECULE_POOL);
    assign mul_p = {{BW{1'b0}}, mul_a} * {{DRAW_W{1'b0}}, mul_b};

    assign sup_t = (TW'(r_supply) < TW'(cnt_val)) ? TW'(r_supply) : TW'(cnt_val);
    assign acc_n = {1'b0, r_acc} + {1'b0, cnt_val};

    // three-element sort of the sampled reactants
    always_comb begin
        srt[0] = r_r[0];
        srt[1] = r_r[1];
        srt[2] = r_r[2];
        if (srt[0] > srt[1]) begin
            tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
        end
        if (srt[1] > srt[2]) begin
            tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp;
        end
        if (srt[0] > srt[1]) begin
            tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
        end else begin
            tmp = '0;
        end
    end

    // multiplicity of the reactant under check
    always_comb begin
        need = '0;
        for (int j = 0; j < 3; j++) begin
            if (r_s[j] == r_s[r_op[1:0]]) begin
                need = need + 2'd1;
            end
        end
    end

    // p3 span for the current (p1, p2) pair
    assign sum12  = MW'(r_p1) + MW'(r_p2);
    assign hi     = r_m - sum12;
    assign hic    = (hi > MW'(CHEMICAL_KINDS)) ? MW'(CHEMICAL_KINDS) : hi;
    assign span_m = (hic >= MW'(r_p2)) ? (hic - MW'(r_p2) + MW'(1)) : '0;
    assign span   = {{(NW-MW){1'b0}}, span_m};
    assign k_off  = r_k - r_eacc;

    assign lim  = (LW'(r_limit) > LW'(RULE_DEPTH)) ? LW'(RULE_DEPTH) : LW'(r_limit);
    assign full = (LW'(r_used) >= lim);

    assign ap_addr = (r_op < 3'd3) ? r_s[r_op[1:0]] : r_p[2'(r_op - 3'd3)];

    // count memory port control
    always_comb begin
        cnt_ra = '0;
        cnt_we = 1'b0;
        cnt_wd = '0;
        case (r_state)
            S_RD_ISS:  cnt_ra = r_idx;
            S_SUP_ISS: cnt_ra = r_op[0] ? KW'(1) : '0;
            S_WK_ISS:  cnt_ra = r_wc;
            S_ND_ISS:  cnt_ra = r_s[r_op[1:0]];
            S_AP_ISS:  cnt_ra = ap_addr;
            S_SUP_USE: begin
                cnt_we = 1'b1;
                cnt_wd = r_op[0] ? (cnt_val + CW'(r_t)) : (cnt_val - CW'(sup_t));
            end
            S_AP_USE: begin
                cnt_we = 1'b1;
                cnt_wd = (r_op < 3'd3) ? (cnt_val - CW'(1)) : (cnt_val + CW'(1));
            end
            default: cnt_ra = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_cq_a] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[cnt_ra];
        r_cq_a  <= cnt_ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NK; e++) begin
                r_cnt_vld[e] <= 1'b0;
            end
            r_cq_v <= 1'b0;
        end else begin
            if (cnt_we) begin
                r_cnt_vld[r_cq_a] <= 1'b1;
            end
            r_cq_v <= r_cnt_vld[cnt_ra] | (cnt_we && (r_cq_a == cnt_ra));
        end
    end

    // rule memory: written once per new rule, read during the search
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRULE) begin
            r_rule_mem[r_used[SW-1:0]] <= {r_s[0], r_s[1], r_s[2], r_p[0], r_p[1], r_p[2]};
        end
        r_rule_q  <= r_rule_mem[r_si[SW-1:0]];
        r_rq_seed <= (r_si < UW'(SEED_COUNT));
        r_rq_idx  <= r_si[1:0];
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_supply <= SUPPLY_RESET;
            r_limit  <= LIMIT_RESET;
            r_used   <= UW'(SEED_COUNT);
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SUPPLY) begin
                    r_supply <= i_cfg_data[SUPPLY_W-1:0];
                end else begin
                    r_limit <= i_cfg_data[LIMIT_W-1:0];
                end
            end
            // the finish state loads the next word itself
            if (o_valid && i_ready && r_state != S_FIN) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_draw[0] <= i_first_draw;
                        r_draw[1] <= i_second_draw;
                        r_draw[2] <= i_third_draw;
                        r_draw[3] <= i_product_draw;
                        r_idx     <= i_chemical_index;
                        r_op      <= '0;
                        r_slot    <= '0;
                        r_cntv    <= '0;
                        for (int j = 0; j < 3; j++) begin
                            r_s[j] <= '0;
                            r_p[j] <= '0;
                        end
                        r_state <= i_action ? S_RD_ISS : S_SUP_ISS;
                    end
                end
                S_RD_ISS: begin
                    r_status <= ST_READ;
                    // a chemical past the last kind reads as zero
                    r_state  <= (r_idx > KW'(CHEMICAL_KINDS)) ? S_FIN : S_RD_USE;
                end
                S_RD_USE: begin
                    r_cntv  <= cnt_val;
                    r_state <= S_FIN;
                end
                S_SUP_ISS: begin
                    r_state <= S_SUP_USE;
                end
                S_SUP_USE: begin
                    // first pass drains empty, second pass fills chemical one
                    if (!r_op[0]) begin
                        r_t     <= sup_t;
                        r_op    <= 3'd1;
                        r_state <= S_SUP_ISS;
                    end else begin
                        r_op    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_tgt[r_op[1:0]] <= mul_p[DRAW_W +: CW];
                    if (r_op == 3'd2) begin
                        r_wc    <= '0;
                        r_acc   <= '0;
                        r_got   <= '0;
                        r_state <= S_WK_ISS;
                    end else begin
                        r_op <= r_op + 3'd1;
                    end
                end
                S_WK_ISS: begin
                    r_state <= S_WK_USE;
                end
                S_WK_USE: begin
                    // prefix walk, all three targets resolved in one pass
                    r_acc <= acc_n[CW-1:0];
                    for (int j = 0; j < 3; j++) begin
                        if (!r_got[j]) begin
                            if (acc_n > {1'b0, r_tgt[j]}) begin
                                r_r[j]   <= r_cq_a;
                                r_got[j] <= 1'b1;
                            end else if (r_wc == KW'(CHEMICAL_KINDS)) begin
                                r_r[j] <= KW'(CHEMICAL_KINDS);
                            end
                        end
                    end
                    if (r_wc == KW'(CHEMICAL_KINDS)) begin
                        r_state <= S_SORT;
                    end else begin
                        r_wc    <= r_wc + KW'(1);
                        r_state <= S_WK_ISS;
                    end
                end
                S_SORT: begin
                    for (int j = 0; j < 3; j++) begin
                        r_s[j] <= srt[j];
                    end
                    r_op    <= '0;
                    r_state <= S_ND_ISS;
                end
                S_ND_ISS: begin
                    r_state <= S_ND_USE;
                end
                S_ND_USE: begin
                    if ({{(CW-2){1'b0}}, need} > cnt_val) begin
                        r_status <= ST_SHORT;
                        r_state  <= S_FIN;
                    end else if (r_op == 3'd2) begin
                        r_si    <= '0;
                        r_state <= S_SR_ISS;
                    end else begin
                        r_op    <= r_op + 3'd1;
                        r_state <= S_ND_ISS;
                    end
                end
                S_SR_ISS: begin
                    r_state <= (r_si >= r_used) ? S_MISS : S_SR_USE;
                end
                S_SR_USE: begin
                    if (rule_ent[5*KW +: KW] == r_s[0] &&
                        rule_ent[4*KW +: KW] == r_s[1] &&
                        rule_ent[3*KW +: KW] == r_s[2]) begin
                        r_p[0]   <= rule_ent[2*KW +: KW];
                        r_p[1]   <= rule_ent[KW +: KW];
                        r_p[2]   <= rule_ent[0 +: KW];
                        r_slot   <= r_si[SW-1:0];
                        r_status <= ST_OLD;
                        r_op     <= '0;
                        r_state  <= S_AP_ISS;
                    end else begin
                        r_si    <= r_si + UW'(1);
                        r_state <= S_SR_ISS;
                    end
                end
                S_MISS: begin
                    if (full) begin
                        r_status <= ST_FULL;
                        r_state  <= S_FIN;
                    end else begin
                        r_m     <= MW'(r_s[0]) + MW'(r_s[1]) + MW'(r_s[2]);
                        r_p1    <= '0;
                        r_p2    <= '0;
                        r_eacc  <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_ENUM;
                    end
                end
                S_ENUM: begin
                    // one (p1, p2) pair per cycle; first pass counts, second selects
                    if (r_p1 > PW'(CHEMICAL_KINDS) || MW'(r_p1) > r_m) begin
                        if (!r_pass) begin
                            r_n     <= r_eacc;
                            r_state <= S_KMUL;
                        end else begin
                            for (int j = 0; j < 3; j++) begin
                                r_p[j] <= '0;
                            end
                            r_state <= S_WRULE;
                        end
                    end else if (r_p2 > PW'(CHEMICAL_KINDS) || sum12 > r_m) begin
                        r_p1 <= r_p1 + PW'(1);
                        r_p2 <= r_p1 + PW'(1);
                    end else if (r_pass && (r_k < r_eacc + span)) begin
                        r_p[0]  <= r_p1[KW-1:0];
                        r_p[1]  <= r_p2[KW-1:0];
                        r_p[2]  <= r_p2[KW-1:0] + k_off[KW-1:0];
                        r_state <= S_WRULE;
                    end else begin
                        r_eacc <= r_eacc + span;
                        r_p2   <= r_p2 + PW'(1);
                    end
                end
                S_KMUL: begin
                    r_k     <= mul_p[DRAW_W +: NW];
                    r_eacc  <= '0;
                    r_p1    <= '0;
                    r_p2    <= '0;
                    r_pass  <= 1'b1;
                    r_state <= S_ENUM;
                end
                S_WRULE: begin
                    r_slot   <= r_used[SW-1:0];
                    r_used   <= r_used + UW'(1);
                    r_status <= ST_NEW;
                    r_op     <= '0;
                    r_state  <= S_AP_ISS;
                end
                S_AP_ISS: begin
                    r_state <= S_AP_USE;
                end
                S_AP_USE: begin
                    // three decrements for reactants, then three increments
                    if (r_op == 3'd5) begin
                        r_state <= S_FIN;
                    end else begin
                        r_op    <= r_op + 3'd1;
                        r_state <= S_AP_ISS;
                    end
                end
                S_FIN: begin
                    if (!o_valid || i_ready) begin
                        o_valid         <= 1'b1;
                        o_status        <= r_status;
                        o_reactant_low  <= r_s[0];
                        o_reactant_mid  <= r_s[1];
                        o_reactant_high <= r_s[2];
                        o_product_low   <= r_p[0];
                        o_product_mid   <= r_p[1];
                        o_product_high  <= r_p[2];
                        o_rule_slot     <= r_slot;
                        o_count_value   <= r_cntv;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
